[sv/fq_pkg.sv]
// Shared types and constants for the Q24.8 fixed-point ALU.
`default_nettype none
package fq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 4;
    localparam int FRAC_BITS = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } op_t;

    // Per-beat data that rides alongside the divider chain.
    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [DATA_W-1:0]     res;
        logic signed [2*DATA_W-1:0] prod;
        logic                  less;
        logic                  greater;
        logic                  equal;
        logic                  dz;
        logic                  neg;
    } side_t;

endpackage
`default_nettype wire

[sv/fixed_point_q24_8_alu.sv]
// Top level of the signed Q24.8 fixed-point ALU.
// Every opcode passes through the same stages from accept to result, the
// front stage, the divider chain that resolves one quotient bit per stage and
// the output stage, so results leave in order. One beat is accepted per cycle
// unless the output is stalled; the whole pipeline holds while the
// output beat is stalled, so in_ready follows out_ready when the last stage
// is full. Compare flags are produced for every opcode; a zero divisor yields
// result 0 with div_by_zero set, and unused opcodes yield 0.
`default_nettype none
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = fq_pkg::FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [fq_pkg::OP_W-1:0]           op,
    input  wire logic signed [fq_pkg::DATA_W-1:0]  operand_a,
    input  wire logic signed [fq_pkg::DATA_W-1:0]  operand_b,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [fq_pkg::DATA_W-1:0]       result_raw,
    output logic                                   a_less,
    output logic                                   a_greater,
    output logic                                   a_equal,
    output logic                                   div_by_zero
);

    localparam int DW    = fq_pkg::DATA_W;
    localparam int NUM_W = DW + FRAC_BITS;
    // stage 1, divider stages, output stage
    localparam int DEPTH = NUM_W + 2;

    logic en;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    // front stage
    fq_pkg::side_t    s1_next;
    fq_pkg::side_t    s1_reg;
    logic [NUM_W-1:0] num_next;
    logic [NUM_W-1:0] num_reg;
    logic [DW-1:0]    den_next;
    logic [DW-1:0]    den_reg;
    logic [DW-1:0]    abs_a;
    logic [NUM_W-1:0] quot;

    fq_pkg::side_t side_reg [NUM_W];

    logic [DW-1:0]    out_res_next;
    logic [DW-1:0]    out_res_reg;
    fq_pkg::side_t    out_side_reg;

    assign en       = ~valid_reg[DEPTH-1] | out_ready;
    assign in_ready = en;

    always_comb
    begin
        s1_next         = '0;
        s1_next.op      = op;
        s1_next.less    = operand_a < operand_b;
        s1_next.greater = operand_a > operand_b;
        s1_next.equal   = operand_a == operand_b;
        s1_next.prod    = operand_a * operand_b;
        s1_next.dz      = (op == fq_pkg::OP_DIV) && (operand_b == '0);
        s1_next.neg     = operand_a[DW-1] ^ operand_b[DW-1];
        unique case (op)
            fq_pkg::OP_ADD:      s1_next.res = operand_a + operand_b;
            fq_pkg::OP_SUB:      s1_next.res = operand_a - operand_b;
            fq_pkg::OP_MIN:      s1_next.res = s1_next.less ? operand_a : operand_b;
            fq_pkg::OP_MAX:      s1_next.res = s1_next.greater ? operand_a : operand_b;
            fq_pkg::OP_INC:      s1_next.res = operand_a + DW'(1);
            fq_pkg::OP_DEC:      s1_next.res = operand_a - DW'(1);
            fq_pkg::OP_FROM_INT: s1_next.res = operand_a << FRAC_BITS;
            fq_pkg::OP_TO_INT:   s1_next.res = operand_a >>> FRAC_BITS;
            default:             s1_next.res = '0;
        endcase
        abs_a    = operand_a[DW-1] ? DW'(-operand_a) : operand_a;
        den_next = operand_b[DW-1] ? DW'(-operand_b) : operand_b;
        num_next = {abs_a, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    fq_div_pipe #(.NUM_W(NUM_W)) u_div (
        .clk  (clk),
        .en   (en),
        .num  (num_reg),
        .den  (den_reg),
        .quot (quot)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s1_reg;
            for (int k = 1; k < NUM_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_comb
    begin
        unique case (side_reg[NUM_W-1].op)
            fq_pkg::OP_MUL:
                out_res_next = side_reg[NUM_W-1].prod[FRAC_BITS +: DW];
            fq_pkg::OP_DIV:
                if (side_reg[NUM_W-1].dz)
                    out_res_next = '0;
                else if (side_reg[NUM_W-1].neg)
                    out_res_next = DW'(-quot);
                else
                    out_res_next = quot[DW-1:0];
            default:
                out_res_next = side_reg[NUM_W-1].res;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg  <= out_res_next;
            out_side_reg <= side_reg[NUM_W-1];
        end
    end

    assign valid_next = {valid_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    assign out_valid   = valid_reg[DEPTH-1];
    assign result_raw  = out_res_reg;
    assign a_less      = out_side_reg.less;
    assign a_greater   = out_side_reg.greater;
    assign a_equal     = out_side_reg.equal;
    assign div_by_zero = out_side_reg.dz;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> result_raw == '0)
        else $error("divide by zero with nonzero result");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({a_less, a_greater, a_equal}))
        else $error("compare flags not exclusive");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    a_front: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted beat not captured");

endmodule
`default_nettype wire

[sv/fq_div_stage.sv]
// One restoring-division step: produces one quotient bit per register stage.
`default_nettype none
module fq_div_stage #(
    parameter int NUM_W = fq_pkg::DATA_W + fq_pkg::FRAC_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [fq_pkg::DATA_W-1:0]   rem_in,
    input  wire logic [NUM_W-1:0]            num_in,
    input  wire logic [fq_pkg::DATA_W-1:0]   den_in,
    output logic [fq_pkg::DATA_W-1:0]        rem_out,
    output logic [NUM_W-1:0]                 num_out,
    output logic [fq_pkg::DATA_W-1:0]        den_out
);

    logic [fq_pkg::DATA_W:0]   trial;
    logic [fq_pkg::DATA_W:0]   diff;
    logic                      qbit;
    logic [fq_pkg::DATA_W-1:0] rem_next;
    logic [NUM_W-1:0]          num_next;
    logic [fq_pkg::DATA_W-1:0] rem_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [fq_pkg::DATA_W-1:0] den_reg;

    always_comb
    begin
        trial    = {rem_in, num_in[NUM_W-1]};
        diff     = trial - {1'b0, den_in};
        qbit     = ~diff[fq_pkg::DATA_W];
        rem_next = qbit ? diff[fq_pkg::DATA_W-1:0] : trial[fq_pkg::DATA_W-1:0];
        // dividend bits shift out the top, quotient bits shift in the bottom
        num_next = {num_in[NUM_W-2:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            den_reg <= den_in;
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;

endmodule
`default_nettype wire

[sv/fq_div_pipe.sv]
// Unsigned divider chain, one quotient bit per stage.
`default_nettype none
module fq_div_pipe #(
    parameter int NUM_W = fq_pkg::DATA_W + fq_pkg::FRAC_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [NUM_W-1:0]           num,
    input  wire logic [fq_pkg::DATA_W-1:0]  den,
    output logic [NUM_W-1:0]                quot
);

    logic [fq_pkg::DATA_W-1:0] rem_w [NUM_W+1];
    logic [NUM_W-1:0]          num_w [NUM_W+1];
    logic [fq_pkg::DATA_W-1:0] den_w [NUM_W+1];

    assign rem_w[0] = '0;
    assign num_w[0] = num;
    assign den_w[0] = den;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        fq_div_stage #(.NUM_W(NUM_W)) u_stage (
            .clk     (clk),
            .en      (en),
            .rem_in  (rem_w[k]),
            .num_in  (num_w[k]),
            .den_in  (den_w[k]),
            .rem_out (rem_w[k+1]),
            .num_out (num_w[k+1]),
            .den_out (den_w[k+1])
        );
    end

    assign quot = num_w[NUM_W];

endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench for the Q24.8 fixed-point ALU: directed corners, then random beats.
`timescale 1ns / 1ps
module tb;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [fq_pkg::OP_W-1:0]          op;
    logic signed [fq_pkg::DATA_W-1:0] operand_a;
    logic signed [fq_pkg::DATA_W-1:0] operand_b;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [fq_pkg::DATA_W-1:0] result_raw;
    logic                             a_less;
    logic                             a_greater;
    logic                             a_equal;
    logic                             div_by_zero;

    typedef struct packed {
        logic [fq_pkg::DATA_W-1:0] res;
        logic                      less;
        logic                      greater;
        logic                      equal;
        logic                      dz;
    } alu_out_t;

    alu_out_t expected_q[$];
    int       mismatches  = 0;
    int       idle_cycles = 0;
    bit       timed_out   = 1'b0;
    bit       stall_en    = 1'b1;

    localparam int LATENCY  = fq_pkg::FRAC_BITS + 34;
    localparam int WATCHDOG = 20000;

    fixed_point_q24_8_alu uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_raw(result_raw), .a_less(a_less), .a_greater(a_greater),
        .a_equal(a_equal), .div_by_zero(div_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic alu_out_t alu_predict(logic [fq_pkg::OP_W-1:0] code,
                                             logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_out_t           r;
        logic signed [63:0] wide;
        logic signed [63:0] num;
        r = '0;
        r.less    = a < b;
        r.greater = a > b;
        r.equal   = a == b;
        case (code)
            fq_pkg::OP_ADD: r.res = a + b;
            fq_pkg::OP_SUB: r.res = a - b;
            fq_pkg::OP_MUL:
            begin
                wide  = 64'(a) * 64'(b);
                r.res = 32'(wide >>> fq_pkg::FRAC_BITS);
            end
            fq_pkg::OP_DIV:
            begin
                if (b == 0)
                    r.dz = 1'b1;
                else
                begin
                    num   = 64'(a) <<< fq_pkg::FRAC_BITS;
                    r.res = 32'(num / 64'(b));
                end
            end
            fq_pkg::OP_MIN: r.res = (a < b) ? a : b;
            fq_pkg::OP_MAX: r.res = (a > b) ? a : b;
            fq_pkg::OP_INC: r.res = a + 32'sd1;
            fq_pkg::OP_DEC: r.res = a - 32'sd1;
            fq_pkg::OP_FROM_INT: r.res = a << fq_pkg::FRAC_BITS;
            fq_pkg::OP_TO_INT: r.res = a >>> fq_pkg::FRAC_BITS;
            default: r.res = '0;
        endcase
        return r;
    endfunction

    // Drive one beat at the falling edge and hold it until accepted.
    task automatic send_beat(logic [fq_pkg::OP_W-1:0] code, logic [31:0] a, logic [31:0] b);
        @(negedge clk);
        in_valid  <= 1'b1;
        op        <= code;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(alu_predict(code, a, b));
    endtask

    task automatic go_idle(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n)
            @(negedge clk);
    endtask

    task automatic drain();
        go_idle(0);
        while (expected_q.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 512) - 256;
            3: return 32'(signed'($urandom_range(0, 65535)) - 32768) << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] corners [5];
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0100};
        for (int i = 0; i < 10; i++)
            send_beat(fq_pkg::op_t'(i), corners[i % 5], corners[(i + 2) % 5]);
        send_beat(fq_pkg::OP_DIV, 32'h0000_0500, 32'h0);
        send_beat(fq_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_beat(fq_pkg::OP_DIV, 32'hffff_fd00, 32'h0000_0200);
        send_beat(fq_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_beat(fq_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001);
        send_beat(fq_pkg::OP_MIN, 32'h0000_1234, 32'h0000_1234);
        send_beat(fq_pkg::OP_MAX, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(fq_pkg::OP_TO_INT, 32'hffff_ff01, 32'h0);
        send_beat(4'd10, 32'h1, 32'h2);
        send_beat(4'd15, 32'hffff_ffff, 32'h0);
        // hold off until the pipe is empty
        drain();
    endtask

    task automatic test_random(int count);
        int burst;
        logic [fq_pkg::OP_W-1:0] code;
        while (count > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && count > 0)
            begin
                code = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                    : 4'($urandom_range(0, 9));
                send_beat(code, rand_operand(),
                          ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand());
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0)
                go_idle($urandom_range(1, 12));
        end
        drain();
    endtask

    // Receiver stall pattern, with quiet stretches of no stalling.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (!stall_en)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) < 60);
    end

    always @(negedge clk)
        if ($urandom_range(0, 199) == 0)
            stall_en <= ~stall_en;

    // Check each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        alu_out_t want;
        alu_out_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{result_raw, a_less, a_greater, a_equal, div_by_zero};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: res exp %h got %h, lt/gt/eq/dz exp %b got %b",
                                 want.res, got.res, want[3:0], got[3:0]);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = '0;
        operand_a   = '0;
        operand_b   = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(800);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[filelist.f]
sv/fq_pkg.sv
sv/fq_div_stage.sv
sv/fq_div_pipe.sv
sv/fixed_point_q24_8_alu.sv
bench/tb.sv
